@@ rtl/mi3_pkg.sv @@
`default_nettype none

package mi3_pkg;

   // default word format, signed q16.16
   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   // matrix dimension and element count
   localparam int DIM   = 3;
   localparam int ELEMS = DIM * DIM;

endpackage

`default_nettype wire

@@ rtl/mi3_div_lane.sv @@
`default_nettype none

module mi3_div_lane #(
   parameter int WORD_BITS = mi3_pkg::WORD_BITS_DEF,
   parameter int NUM_BITS  = 3 * mi3_pkg::WORD_BITS_DEF,
   parameter int DEN_BITS  = 3 * mi3_pkg::WORD_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic [NUM_BITS-1:0]  num_mag,
   input  wire logic [DEN_BITS-1:0]  den_mag,
   output logic      [WORD_BITS-1:0] quot,
   output logic                      too_big
);

   localparam int HIGH_BITS = NUM_BITS - WORD_BITS;
   localparam int REM_BITS  = ((HIGH_BITS > DEN_BITS) ? HIGH_BITS : DEN_BITS) + 1;

   logic [REM_BITS-1:0]  rem_ff  [WORD_BITS];
   logic [WORD_BITS-1:0] low_ff  [WORD_BITS];
   logic [WORD_BITS-1:0] quot_ff [WORD_BITS];
   logic [DEN_BITS-1:0]  den_ff  [WORD_BITS];
   logic                 big_ff  [WORD_BITS];

   logic [REM_BITS-1:0]  rem_in  [WORD_BITS];
   logic [WORD_BITS-1:0] low_in  [WORD_BITS];
   logic [WORD_BITS-1:0] quot_in [WORD_BITS];

   logic [REM_BITS-1:0]  src_rem  [WORD_BITS];
   logic [WORD_BITS-1:0] src_low  [WORD_BITS];
   logic [WORD_BITS-1:0] src_quot [WORD_BITS];
   logic [DEN_BITS-1:0]  src_den  [WORD_BITS];
   logic                 src_big  [WORD_BITS];
   logic [REM_BITS-1:0]  trial    [WORD_BITS];
   logic                 fits     [WORD_BITS];

   // one quotient bit per stage, msb first
   for (genvar s = 0; s < WORD_BITS; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign src_rem[s]  = REM_BITS'(num_mag[NUM_BITS-1:WORD_BITS]);
         assign src_low[s]  = num_mag[WORD_BITS-1:0];
         assign src_quot[s] = '0;
         assign src_den[s]  = den_mag;
         // quotient would need more than WORD_BITS bits
         assign src_big[s]  = REM_BITS'(num_mag[NUM_BITS-1:WORD_BITS])
                              >= REM_BITS'(den_mag);
      end else begin : g_next
         assign src_rem[s]  = rem_ff[s-1];
         assign src_low[s]  = low_ff[s-1];
         assign src_quot[s] = quot_ff[s-1];
         assign src_den[s]  = den_ff[s-1];
         assign src_big[s]  = big_ff[s-1];
      end

      assign trial[s]   = {src_rem[s][REM_BITS-2:0], src_low[s][WORD_BITS-1]};
      assign fits[s]    = trial[s] >= REM_BITS'(src_den[s]);
      assign rem_in[s]  = fits[s] ? (trial[s] - REM_BITS'(src_den[s])) : trial[s];
      assign low_in[s]  = {src_low[s][WORD_BITS-2:0], 1'b0};
      assign quot_in[s] = {src_quot[s][WORD_BITS-2:0], fits[s]};

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in[s];
         low_ff[s]  <= low_in[s];
         quot_ff[s] <= quot_in[s];
         den_ff[s]  <= src_den[s];
         big_ff[s]  <= src_big[s];
      end
   end

   assign quot    = quot_ff[WORD_BITS-1];
   assign too_big = big_ff[WORD_BITS-1];

endmodule

`default_nettype wire

@@ rtl/matrix3_inverse_core.sv @@
`default_nettype none

// 3x3 matrix inverse by adjugate, signed fixed point (default q16.16). one
// transaction is accepted in every cycle that start is high; busy is always
// low, since the pipeline never stalls. the result of each transaction comes
// out after the front stages, the divider stages and the output register,
// on a single-cycle rsp_strobe pulse, in order; the receiver cannot hold it
// off, so it must take every strobe. the divider has nine
// lanes of restoring division, one quotient bit per register stage. ahead of
// it sit seven stages: element products, cofactors, split determinant
// products, three determinant add steps, and sign/magnitude. a zero
// determinant gives all-zero entries with rsp_singular set; an entry beyond
// the word range saturates and sets rsp_overflow. quotients truncate toward
// zero.

module matrix3_inverse_core #(
   parameter int WORD_BITS = mi3_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic signed [WORD_BITS-1:0] req_m00,
   input  wire logic signed [WORD_BITS-1:0] req_m01,
   input  wire logic signed [WORD_BITS-1:0] req_m02,
   input  wire logic signed [WORD_BITS-1:0] req_m10,
   input  wire logic signed [WORD_BITS-1:0] req_m11,
   input  wire logic signed [WORD_BITS-1:0] req_m12,
   input  wire logic signed [WORD_BITS-1:0] req_m20,
   input  wire logic signed [WORD_BITS-1:0] req_m21,
   input  wire logic signed [WORD_BITS-1:0] req_m22,
   output logic                             rsp_strobe,
   output logic signed      [WORD_BITS-1:0] rsp_r00,
   output logic signed      [WORD_BITS-1:0] rsp_r01,
   output logic signed      [WORD_BITS-1:0] rsp_r02,
   output logic signed      [WORD_BITS-1:0] rsp_r10,
   output logic signed      [WORD_BITS-1:0] rsp_r11,
   output logic signed      [WORD_BITS-1:0] rsp_r12,
   output logic signed      [WORD_BITS-1:0] rsp_r20,
   output logic signed      [WORD_BITS-1:0] rsp_r21,
   output logic signed      [WORD_BITS-1:0] rsp_r22,
   output logic                             rsp_singular,
   output logic                             rsp_overflow
);

   localparam int DIM   = mi3_pkg::DIM;
   localparam int ELEMS = mi3_pkg::ELEMS;

   // widths of the exact intermediates
   localparam int PROD_BITS = 2 * WORD_BITS;          // element product
   localparam int COF_BITS  = 2 * WORD_BITS + 1;      // cofactor
   localparam int PART_BITS = 2 * WORD_BITS + 1;      // element x cofactor half
   localparam int DET_BITS  = 3 * WORD_BITS + 4;      // determinant
   localparam int NUM_BITS  = COF_BITS + 2 * FRAC_BITS;  // cofactor scaled up

   // seven front stages, the divider, one output stage
   localparam int FRONT = 7;
   localparam int LAT   = FRONT + WORD_BITS + 1;

   // nothing ever holds the pipeline
   assign busy = 1'b0;

   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   logic signed [WORD_BITS-1:0] elem [ELEMS];

   assign elem[0] = req_m00;
   assign elem[1] = req_m01;
   assign elem[2] = req_m02;
   assign elem[3] = req_m10;
   assign elem[4] = req_m11;
   assign elem[5] = req_m12;
   assign elem[6] = req_m20;
   assign elem[7] = req_m21;
   assign elem[8] = req_m22;

   // valid bits march alongside the data
   assign vld_in = {vld_ff[LAT-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage 1: the two products of every cofactor
   // ---------------------------------------------------------------------
   logic signed [PROD_BITS-1:0] pa_in [ELEMS];
   logic signed [PROD_BITS-1:0] pb_in [ELEMS];
   logic signed [PROD_BITS-1:0] pa_ff [ELEMS];
   logic signed [PROD_BITS-1:0] pb_ff [ELEMS];
   logic signed [WORD_BITS-1:0] row0_s1_ff [DIM];

   // adjugate entry (i,j) is the cofactor of element (j,i)
   for (genvar i = 0; i < DIM; i++) begin : g_prod_row
      for (genvar j = 0; j < DIM; j++) begin : g_prod_col
         localparam int I1 = (i + 1) % DIM;
         localparam int I2 = (i + 2) % DIM;
         localparam int J1 = (j + 1) % DIM;
         localparam int J2 = (j + 2) % DIM;
         assign pa_in[i*DIM+j] = elem[J1*DIM+I1] * elem[J2*DIM+I2];
         assign pb_in[i*DIM+j] = elem[J1*DIM+I2] * elem[J2*DIM+I1];
      end
   end

   always_ff @(posedge clock) begin
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      for (int k = 0; k < DIM; k++) begin
         row0_s1_ff[k] <= elem[k];
      end
   end

   // ---------------------------------------------------------------------
   // stage 2: cofactors
   // ---------------------------------------------------------------------
   logic signed [COF_BITS-1:0]  cof_in     [ELEMS];
   logic signed [COF_BITS-1:0]  cof_s2_ff  [ELEMS];
   logic signed [WORD_BITS-1:0] row0_s2_ff [DIM];

   for (genvar e = 0; e < ELEMS; e++) begin : g_cof
      assign cof_in[e] = COF_BITS'(pa_ff[e]) - COF_BITS'(pb_ff[e]);
   end

   always_ff @(posedge clock) begin
      cof_s2_ff  <= cof_in;
      row0_s2_ff <= row0_s1_ff;
   end

   // ---------------------------------------------------------------------
   // stage 3: row 0 times cofactor, cofactor split in a low unsigned word
   // and a signed high part
   // ---------------------------------------------------------------------
   logic signed [PART_BITS-1:0] dlo_in [DIM];
   logic signed [PART_BITS-1:0] dhi_in [DIM];
   logic signed [PART_BITS-1:0] dlo_ff [DIM];
   logic signed [PART_BITS-1:0] dhi_ff [DIM];
   logic signed [COF_BITS-1:0]  cof_s3_ff [ELEMS];

   for (genvar k = 0; k < DIM; k++) begin : g_dpart
      assign dlo_in[k] = row0_s2_ff[k]
                         * $signed({1'b0, cof_s2_ff[k*DIM][WORD_BITS-1:0]});
      assign dhi_in[k] = row0_s2_ff[k]
                         * $signed(cof_s2_ff[k*DIM][COF_BITS-1:WORD_BITS]);
   end

   always_ff @(posedge clock) begin
      dlo_ff    <= dlo_in;
      dhi_ff    <= dhi_in;
      cof_s3_ff <= cof_s2_ff;
   end

   // ---------------------------------------------------------------------
   // stages 4 to 6: recombine halves, then sum the three terms
   // ---------------------------------------------------------------------
   logic signed [DET_BITS-1:0] term_in [DIM];
   logic signed [DET_BITS-1:0] term_ff [DIM];
   logic signed [COF_BITS-1:0] cof_s4_ff [ELEMS];
   logic signed [DET_BITS-1:0] psum_in;
   logic signed [DET_BITS-1:0] psum_ff;
   logic signed [DET_BITS-1:0] last_ff;
   logic signed [COF_BITS-1:0] cof_s5_ff [ELEMS];
   logic signed [DET_BITS-1:0] det_in;
   logic signed [DET_BITS-1:0] det_ff;
   logic signed [COF_BITS-1:0] cof_s6_ff [ELEMS];

   for (genvar k = 0; k < DIM; k++) begin : g_term
      assign term_in[k] = (DET_BITS'(dhi_ff[k]) <<< WORD_BITS) + DET_BITS'(dlo_ff[k]);
   end

   assign psum_in = term_ff[0] + term_ff[1];
   assign det_in  = psum_ff + last_ff;

   always_ff @(posedge clock) begin
      term_ff   <= term_in;
      cof_s4_ff <= cof_s3_ff;
      psum_ff   <= psum_in;
      last_ff   <= term_ff[DIM-1];
      cof_s5_ff <= cof_s4_ff;
      det_ff    <= det_in;
      cof_s6_ff <= cof_s5_ff;
   end

   // ---------------------------------------------------------------------
   // stage 7: signs and magnitudes for the divider
   // ---------------------------------------------------------------------
   logic                      den_neg;
   logic [DET_BITS-1:0]       den_mag_in;
   logic [DET_BITS-1:0]       den_mag_ff;
   logic                      den_zero_ff;
   logic [ELEMS-1:0]          qneg_in;
   logic [ELEMS-1:0]          qneg_s7_ff;
   logic [COF_BITS-1:0]       cmag [ELEMS];
   logic [NUM_BITS-1:0]       num_mag_in [ELEMS];
   logic [NUM_BITS-1:0]       num_mag_ff [ELEMS];

   assign den_neg    = det_ff[DET_BITS-1];
   assign den_mag_in = den_neg ? DET_BITS'(-det_ff) : DET_BITS'(det_ff);

   for (genvar e = 0; e < ELEMS; e++) begin : g_num
      assign cmag[e] = cof_s6_ff[e][COF_BITS-1] ? COF_BITS'(-cof_s6_ff[e])
                                                : COF_BITS'(cof_s6_ff[e]);
      // numerator is the cofactor times 2^(2*frac)
      assign num_mag_in[e] = {cmag[e], {(2 * FRAC_BITS){1'b0}}};
      assign qneg_in[e]    = cof_s6_ff[e][COF_BITS-1] ^ den_neg;
   end

   always_ff @(posedge clock) begin
      den_mag_ff  <= den_mag_in;
      den_zero_ff <= (det_ff == '0);
      qneg_s7_ff  <= qneg_in;
      num_mag_ff  <= num_mag_in;
   end

   // ---------------------------------------------------------------------
   // divider lanes, with sign and singular flags delayed to match
   // ---------------------------------------------------------------------
   logic [WORD_BITS-1:0] quot [ELEMS];
   logic [ELEMS-1:0]     too_big;
   logic [ELEMS-1:0]     qneg_ff [WORD_BITS];
   logic                 sing_ff [WORD_BITS];

   for (genvar e = 0; e < ELEMS; e++) begin : g_lane
      mi3_div_lane #(
         .WORD_BITS (WORD_BITS),
         .NUM_BITS  (NUM_BITS),
         .DEN_BITS  (DET_BITS)
      ) u_lane (
         .clock   (clock),
         .num_mag (num_mag_ff[e]),
         .den_mag (den_mag_ff),
         .quot    (quot[e]),
         .too_big (too_big[e])
      );
   end

   for (genvar s = 0; s < WORD_BITS; s++) begin : g_flag
      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            qneg_ff[s] <= qneg_s7_ff;
            sing_ff[s] <= den_zero_ff;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            qneg_ff[s] <= qneg_ff[s-1];
            sing_ff[s] <= sing_ff[s-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // output stage: saturate, apply sign, zero on singular
   // ---------------------------------------------------------------------
   logic [ELEMS-1:0]     qneg_out;
   logic                 sing_out;
   logic [ELEMS-1:0]     sat;
   logic [WORD_BITS-1:0] lim   [ELEMS];
   logic [WORD_BITS-1:0] qval  [ELEMS];
   logic [WORD_BITS-1:0] res_in [ELEMS];
   logic [WORD_BITS-1:0] res_ff [ELEMS];
   logic                 sing_res_ff;
   logic                 ovf_res_ff;

   assign qneg_out = qneg_ff[WORD_BITS-1];
   assign sing_out = sing_ff[WORD_BITS-1];

   for (genvar e = 0; e < ELEMS; e++) begin : g_sat
      // negative results reach one step further than positive ones
      assign lim[e] = qneg_out[e] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                  : {1'b0, {(WORD_BITS-1){1'b1}}};
      assign sat[e] = too_big[e] | (quot[e][WORD_BITS-1]
                      & (~qneg_out[e] | (|quot[e][WORD_BITS-2:0])));
      assign qval[e]   = sat[e] ? lim[e] : quot[e];
      assign res_in[e] = sing_out ? '0 : (qneg_out[e] ? (-qval[e]) : qval[e]);
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      sing_res_ff <= sing_out;
      ovf_res_ff  <= ~sing_out & (|sat);
   end

   assign rsp_strobe   = vld_ff[LAT-1];
   assign rsp_r00      = $signed(res_ff[0]);
   assign rsp_r01      = $signed(res_ff[1]);
   assign rsp_r02      = $signed(res_ff[2]);
   assign rsp_r10      = $signed(res_ff[3]);
   assign rsp_r11      = $signed(res_ff[4]);
   assign rsp_r12      = $signed(res_ff[5]);
   assign rsp_r20      = $signed(res_ff[6]);
   assign rsp_r21      = $signed(res_ff[7]);
   assign rsp_r22      = $signed(res_ff[8]);
   assign rsp_singular = sing_res_ff;
   assign rsp_overflow = ovf_res_ff;

endmodule

`default_nettype wire
